// File: sv/vpf_pkg.sv
// Shared types, constants and sizes of the video payload fragmenter.
package vpf_pkg;

    localparam int HEADER_BYTES     = 42;
    localparam int FRAME_BYTES_MAX  = 131072;
    localparam int CONFIG_BYTES_MAX = 16384;

    // Field and state widths.
    localparam int CNT_W     = 18;
    localparam int OFF_W     = 17;
    localparam int LEN_W     = 16;
    localparam int REG_W     = 16;
    localparam int TB_W      = 8;
    localparam int FRM_LEN_W = $clog2(FRAME_BYTES_MAX + 1);
    localparam int FRM_POS_W = $clog2(FRAME_BYTES_MAX);
    localparam int CFG_LEN_W = $clog2(CONFIG_BYTES_MAX + 1);

    // Step counter of the remainder unit, one step per dividend bit.
    localparam int REM_STEP_W = $clog2(REG_W);

    // Queue between classifier and executor.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Payload sizing.
    localparam int HDR_OVERHEAD        = 6;
    localparam int MIN_PAYLOAD         = 7;
    localparam int DEFAULT_MAX_PAYLOAD = 1400;
    localparam int DEFAULT_RESEND      = 16;

    // Fourth header byte codes.
    localparam logic [TB_W-1:0] TB_SINGLE   = 8'h01;
    localparam logic [TB_W-1:0] TB_START    = 8'h40;
    localparam logic [TB_W-1:0] TB_CONT     = 8'h80;
    localparam logic [TB_W-1:0] TB_END      = 8'hC0;
    localparam logic [TB_W-1:0] TB_CFG_FLAG = 8'h10;

    typedef enum logic [1:0] {
        OP_FRAME   = 2'd0,
        OP_HEADER  = 2'd1,
        OP_TABLE   = 2'd2,
        OP_REQUEST = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        SRC_NONE   = 2'd0,
        SRC_CONFIG = 2'd1,
        SRC_FRAME  = 2'd2
    } t_src;

    typedef enum logic [0:0] {
        CFG_MAX_PAYLOAD     = 1'b0,
        CFG_RESEND_INTERVAL = 1'b1
    } t_cfg_idx;

    // One classified command waiting for the executor.
    typedef struct packed {
        t_op                  op;
        logic [FRM_LEN_W-1:0] arg;
    } t_qent;

    // One payload descriptor.
    typedef struct packed {
        t_src              source;
        logic [OFF_W-1:0]  offset;
        logic [LEN_W-1:0]  chunk_len;
        logic [TB_W-1:0]   type_byte;
        logic              marker;
    } t_desc;

    // Status of the remainder unit.
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [REG_W-1:0] rem;
    } t_rem_st;

endpackage

// File: sv/vpf_if.sv
// Channel interfaces of the video payload fragmenter: input, output and configuration.
interface vpf_in_if;
    import vpf_pkg::*;
    logic             valid;
    logic             ready;
    t_op              op;
    logic [CNT_W-1:0] byte_count;
    modport source (output valid, output op, output byte_count, input ready);
    modport sink   (input valid, input op, input byte_count, output ready);
endinterface

interface vpf_out_if;
    import vpf_pkg::*;
    logic              valid;
    logic              ready;
    t_src              src;
    logic [OFF_W-1:0]  offset;
    logic [LEN_W-1:0]  chunk_len;
    logic [TB_W-1:0]   type_byte;
    logic              marker;
    modport source (output valid, output src, output offset, output chunk_len,
                    output type_byte, output marker, input ready);
    modport sink   (input valid, input src, input offset, input chunk_len,
                    input type_byte, input marker, output ready);
endinterface

interface vpf_cfg_if;
    import vpf_pkg::*;
    logic             valid;
    logic             ready;
    t_cfg_idx         index;
    logic [REG_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/vpf_remu.sv
// Iterative remainder unit: one quotient bit per cycle.
module vpf_remu (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [vpf_pkg::REG_W-1:0] i_dividend,
    input  logic [vpf_pkg::REG_W-1:0] i_divisor,
    output vpf_pkg::t_rem_st          o_st
);
    import vpf_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [REM_STEP_W-1:0] r_step;
    logic [REG_W-1:0]      r_rem;
    logic [REG_W-1:0]      r_dvd;
    logic [REG_W-1:0]      r_div;

    logic                  n_busy;
    logic                  n_done;
    logic [REM_STEP_W-1:0] n_step;
    logic [REG_W-1:0]      n_rem;
    logic [REG_W-1:0]      n_dvd;
    logic [REG_W-1:0]      n_div;
    logic [REG_W:0]        trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_div  = r_div;
        trial  = {r_rem, r_dvd[REG_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_rem  = '0;
            n_dvd  = i_dividend;
            n_div  = i_divisor;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_div}) begin
                trial = trial - {1'b0, r_div};
            end
            n_rem = trial[REG_W-1:0];
            n_dvd = {r_dvd[REG_W-2:0], 1'b0};
            n_step = r_step + 1'b1;
            if (r_step == REM_STEP_W'(REG_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_div <= n_div;
    end

    assign o_st.busy = r_busy;
    assign o_st.done = r_done;
    assign o_st.rem  = r_rem;

endmodule

// File: sv/vpf_front.sv
// Front end: accepts input requests, drops bad header loads and saturates lengths.
module vpf_front (
    vpf_in_if.sink                i_in,
    input  logic                  i_full,
    input  logic                  i_hold,
    output logic                  o_push,
    output vpf_pkg::t_qent        o_wdata
);
    import vpf_pkg::*;

    logic [CNT_W-1:0]     cnt;
    logic [CNT_W:0]       tbl_sum;
    logic [FRM_LEN_W-1:0] frm_sat;
    logic [CFG_LEN_W-1:0] tbl_sat;
    logic                 drop;

    always_comb begin
        cnt     = i_in.byte_count;
        tbl_sum = (CNT_W + 1)'(cnt) + (CNT_W + 1)'(HEADER_BYTES);
        frm_sat = (cnt > CNT_W'(FRAME_BYTES_MAX)) ? FRM_LEN_W'(FRAME_BYTES_MAX)
                                                  : FRM_LEN_W'(cnt);
        tbl_sat = (tbl_sum > (CNT_W + 1)'(CONFIG_BYTES_MAX)) ? CFG_LEN_W'(CONFIG_BYTES_MAX)
                                                             : CFG_LEN_W'(tbl_sum);
        drop    = (i_in.op == OP_HEADER) && (cnt != CNT_W'(HEADER_BYTES));

        o_wdata.op = i_in.op;
        case (i_in.op)
            OP_FRAME: o_wdata.arg = frm_sat;
            OP_TABLE: o_wdata.arg = FRM_LEN_W'(tbl_sat);
            default:  o_wdata.arg = '0;
        endcase
    end

    assign i_in.ready = !i_full && !i_hold;
    assign o_push     = i_in.valid && i_in.ready && !drop;

endmodule

// File: sv/vpf_queue.sv
// Short command queue between the front end and the executor.
module vpf_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  vpf_pkg::t_qent       i_wdata,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_valid,
    output vpf_pkg::t_qent       o_rdata
);
    import vpf_pkg::*;

    t_qent              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    logic [Q_CNT_W-1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rd_ptr];

endmodule

// File: sv/vpf_back.sv
// Executor: keeps config and frame positions and emits one descriptor per packet request.
module vpf_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_valid,
    input  vpf_pkg::t_qent            i_q,
    output logic                      o_q_pop,
    input  logic [vpf_pkg::LEN_W-1:0] i_room,
    input  logic [vpf_pkg::REG_W-1:0] i_iv,
    input  vpf_pkg::t_rem_st          i_rem,
    output logic [vpf_pkg::REG_W-1:0] o_frame_counter,
    vpf_out_if.source                 o_out
);
    import vpf_pkg::*;

    logic [CFG_LEN_W-1:0] r_cfg_len;
    logic [CFG_LEN_W-1:0] r_cfg_pos;
    logic                 r_cfg_sent;
    logic [FRM_LEN_W-1:0] r_frm_len;
    logic [FRM_POS_W-1:0] r_frm_pos;
    logic [REG_W-1:0]     r_fcnt;
    logic [REG_W-1:0]     r_resid;
    logic                 r_out_valid;
    t_desc                r_out;

    logic [CFG_LEN_W-1:0] n_cfg_len;
    logic [CFG_LEN_W-1:0] n_cfg_pos;
    logic                 n_cfg_sent;
    logic [FRM_LEN_W-1:0] n_frm_len;
    logic [FRM_POS_W-1:0] n_frm_pos;
    logic [REG_W-1:0]     n_fcnt;
    logic [REG_W-1:0]     n_resid;
    logic                 n_out_valid;
    t_desc                n_out;

    logic                 use_cfg;
    logic [FRM_LEN_W-1:0] sel_total;
    logic [FRM_POS_W-1:0] sel_pos;
    logic [FRM_LEN_W-1:0] remain;
    logic                 last;
    logic [LEN_W-1:0]     cut_len;
    logic [FRM_POS_W-1:0] pos_adv;
    logic [TB_W-1:0]      code;
    logic [REG_W:0]       resid_inc;
    logic [REG_W-1:0]     resid_next;

    // Chunk cut, shared between the config block and the frame.
    always_comb begin
        use_cfg   = !r_cfg_sent || (r_cfg_pos != '0);
        sel_total = use_cfg ? FRM_LEN_W'(r_cfg_len) : r_frm_len;
        sel_pos   = use_cfg ? FRM_POS_W'(r_cfg_pos) : r_frm_pos;
        remain    = (sel_total > FRM_LEN_W'(sel_pos)) ? sel_total - FRM_LEN_W'(sel_pos) : '0;
        last      = remain <= FRM_LEN_W'(i_room);
        cut_len   = last ? remain[LEN_W-1:0] : i_room;
        pos_adv   = sel_pos + FRM_POS_W'(i_room);
        if (sel_pos != '0) begin
            code = last ? TB_END : TB_CONT;
        end else begin
            code = last ? TB_SINGLE : TB_START;
        end
    end

    // Residue of the frame counter by the resend interval.
    always_comb begin
        resid_inc = {1'b0, r_resid} + 1'b1;
        if (&r_fcnt) begin
            resid_next = '0;
        end else if (resid_inc == {1'b0, i_iv}) begin
            resid_next = '0;
        end else begin
            resid_next = resid_inc[REG_W-1:0];
        end
    end

    assign o_q_pop = i_q_valid && !i_rem.busy && !i_rem.done &&
                     ((i_q.op != OP_REQUEST) || !r_out_valid || o_out.ready);

    always_comb begin
        n_cfg_len  = r_cfg_len;
        n_cfg_pos  = r_cfg_pos;
        n_cfg_sent = r_cfg_sent;
        n_frm_len  = r_frm_len;
        n_frm_pos  = r_frm_pos;
        n_fcnt     = r_fcnt;
        n_resid    = r_resid;
        n_out      = r_out;
        n_out_valid = r_out_valid && !o_out.ready;

        if (i_rem.done) begin
            n_resid = i_rem.rem;
        end

        if (o_q_pop) begin
            case (i_q.op)
                OP_FRAME: begin
                    n_frm_len = i_q.arg;
                    n_frm_pos = '0;
                    n_fcnt    = r_fcnt + 1'b1;
                    n_resid   = resid_next;
                    if (resid_next == '0) begin
                        n_cfg_sent = 1'b0;
                    end
                end
                OP_HEADER: begin
                    if (r_cfg_len == '0) begin
                        n_cfg_len = CFG_LEN_W'(HEADER_BYTES);
                    end
                    n_cfg_pos  = '0;
                    n_cfg_sent = 1'b0;
                end
                OP_TABLE: begin
                    n_cfg_len  = i_q.arg[CFG_LEN_W-1:0];
                    n_cfg_pos  = '0;
                    n_cfg_sent = 1'b0;
                end
                OP_REQUEST: begin
                    n_out_valid     = 1'b1;
                    n_out.source    = SRC_NONE;
                    n_out.offset    = '0;
                    n_out.chunk_len = '0;
                    n_out.type_byte = '0;
                    n_out.marker    = 1'b0;
                    if (use_cfg) begin
                        n_out.source    = SRC_CONFIG;
                        n_out.offset    = OFF_W'(r_cfg_pos);
                        n_out.chunk_len = cut_len;
                        n_out.type_byte = code | TB_CFG_FLAG;
                        // A finishing cut always brings the position back to zero.
                        if (last) begin
                            n_cfg_sent = 1'b1;
                            n_cfg_pos  = '0;
                        end else begin
                            n_cfg_pos = CFG_LEN_W'(pos_adv);
                        end
                    end else if (r_frm_len != '0) begin
                        n_out.source    = SRC_FRAME;
                        n_out.offset    = OFF_W'(r_frm_pos);
                        n_out.chunk_len = cut_len;
                        n_out.type_byte = code;
                        if (last) begin
                            n_out.marker = 1'b1;
                            n_frm_len    = '0;
                            n_frm_pos    = '0;
                        end else begin
                            n_frm_pos = pos_adv;
                        end
                    end
                end
                default: begin
                    n_out_valid = r_out_valid && !o_out.ready;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len   <= '0;
            r_cfg_pos   <= '0;
            r_cfg_sent  <= 1'b0;
            r_frm_len   <= '0;
            r_frm_pos   <= '0;
            r_fcnt      <= '0;
            r_resid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cfg_len   <= n_cfg_len;
            r_cfg_pos   <= n_cfg_pos;
            r_cfg_sent  <= n_cfg_sent;
            r_frm_len   <= n_frm_len;
            r_frm_pos   <= n_frm_pos;
            r_fcnt      <= n_fcnt;
            r_resid     <= n_resid;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_frame_counter = r_fcnt;
    assign o_out.valid     = r_out_valid;
    assign o_out.src       = r_out.source;
    assign o_out.offset    = r_out.offset;
    assign o_out.chunk_len = r_out.chunk_len;
    assign o_out.type_byte = r_out.type_byte;
    assign o_out.marker    = r_out.marker;

    a_cfg_pos_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cfg_pos != '0) |-> (r_cfg_pos < r_cfg_len))
        else $error("config read position beyond config length");

    a_frm_pos_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_frm_pos != '0) |-> (FRM_LEN_W'(r_frm_pos) < r_frm_len))
        else $error("frame read position beyond frame length");

    a_resid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_rem.busy && !i_rem.done) |-> (r_resid < i_iv))
        else $error("frame counter residue out of range");

    a_marker_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.marker) |->
        (r_out.source == SRC_FRAME &&
         (r_out.type_byte == TB_SINGLE || r_out.type_byte == TB_END)))
        else $error("marker on a chunk that does not end a frame");

endmodule

// File: sv/video_payload_fragmenter.sv
// Top level of the video payload fragmenter: config registers, front end, queue and executor.
//
// The block turns frame and config loads into a stream of payload descriptors, one per
// packet request (op 3); loads (ops 0 to 2) produce no descriptor. The front end takes one
// request per clock while the queue is not full and no resend_interval write holds it off,
// drops header loads of the wrong length, saturates lengths and puts the command into a
// two-entry queue. The executor pops one command per clock unless the remainder unit is
// busy or done or, for a request, an earlier descriptor still waits on the output and is
// not taken; it updates the config and frame read positions and writes the descriptor
// into an output register, so a descriptor passes the queue and then that register.
// Writing resend_interval starts a remainder unit that works out the frame count modulo
// the new interval one bit per cycle: the input is held off in the cycle of that write and
// while the unit is busy, and the executor waits while it is busy and while the new
// residue is loaded. Writes of max_payload take effect at once. The configuration channel
// is always ready and is meant to be used only while the block is idle.
module video_payload_fragmenter (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vpf_in_if.sink    i_in,
    vpf_out_if.source o_out,
    vpf_cfg_if.sink   i_cfg
);
    import vpf_pkg::*;

    // Effective chunk room (max_payload clamped below, minus the header) and interval.
    logic [LEN_W-1:0] r_room;
    logic [REG_W-1:0] r_iv;

    logic [LEN_W-1:0] n_room;
    logic [REG_W-1:0] n_iv;
    logic             cfg_wr;
    logic             rem_start;
    logic [REG_W-1:0] clamp_mp;

    logic             q_push;
    t_qent            q_wdata;
    logic             q_full;
    logic             q_pop;
    logic             q_valid;
    t_qent            q_rdata;
    t_rem_st          rem_st;
    logic [REG_W-1:0] frame_counter;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid && i_cfg.ready;
    assign rem_start   = cfg_wr && (i_cfg.index == CFG_RESEND_INTERVAL);

    always_comb begin
        n_room   = r_room;
        n_iv     = r_iv;
        clamp_mp = (i_cfg.data < REG_W'(MIN_PAYLOAD)) ? REG_W'(MIN_PAYLOAD) : i_cfg.data;
        if (cfg_wr) begin
            case (i_cfg.index)
                CFG_MAX_PAYLOAD: begin
                    n_room = LEN_W'(clamp_mp - REG_W'(HDR_OVERHEAD));
                end
                CFG_RESEND_INTERVAL: begin
                    // An interval of zero behaves as one.
                    n_iv = (i_cfg.data == '0) ? REG_W'(1) : i_cfg.data;
                end
                default: begin
                    n_room = r_room;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_room <= LEN_W'(DEFAULT_MAX_PAYLOAD - HDR_OVERHEAD);
            r_iv   <= REG_W'(DEFAULT_RESEND);
        end else begin
            r_room <= n_room;
            r_iv   <= n_iv;
        end
    end

    vpf_front u_front (
        .i_in    (i_in),
        .i_full  (q_full),
        .i_hold  (rem_st.busy || rem_start),
        .o_push  (q_push),
        .o_wdata (q_wdata)
    );

    vpf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_rdata (q_rdata)
    );

    vpf_remu u_remu (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (frame_counter),
        .i_divisor  (n_iv),
        .o_st       (rem_st)
    );

    vpf_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q             (q_rdata),
        .o_q_pop         (q_pop),
        .i_room          (r_room),
        .i_iv            (r_iv),
        .i_rem           (rem_st),
        .o_frame_counter (frame_counter),
        .o_out           (o_out)
    );

endmodule
